FILE: rtl/hms_pkg.sv
// Shared constants, types and helper functions for the timestamp parser.
`timescale 1ns / 1ps

package hms_pkg;

    localparam int UNITS_PER_SECOND = 1000000;
    localparam int MAX_COLONS       = 2;
    localparam int SECONDS_WIDTH    = 40;

    localparam int CH_W     = 8;
    localparam int TIME_W   = 63;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 30;
    localparam int WIDX_W   = 4;
    localparam int COLON_W  = 2;
    localparam int PROD_W   = SECONDS_WIDTH + FRAC_W + 1;

    localparam int RADIX_DEC = 10;
    localparam int RADIX_SEX = 60;

    typedef logic [SECONDS_WIDTH-1:0] t_secs;
    typedef logic [FRAC_W-1:0]        t_frac;
    typedef logic [WIDX_W-1:0]        t_widx;
    typedef logic [COLON_W-1:0]       t_colons;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [CH_W-1:0]          t_ch;
    typedef logic [TIME_W-1:0]        t_time;

    typedef struct packed {
        logic  ovf;
        t_secs val;
    } t_sat;

    localparam t_secs SEC_MAX  = '1;
    localparam t_time TIME_MAX = '1;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_COLONS = 2'd1;
    localparam t_status ST_CHAR   = 2'd2;
    localparam t_status ST_SAT    = 2'd3;

    localparam t_ch CH_NUL   = 8'h00;
    localparam t_ch CH_ZERO  = 8'h30;
    localparam t_ch CH_NINE  = 8'h39;
    localparam t_ch CH_COLON = 8'h3a;
    localparam t_ch CH_DOT   = 8'h2e;

    // Saturation never displaces a parse error; the first parse error sticks.
    function automatic t_status note_status(t_status cur, t_status code);
        t_status res;
        res = cur;
        if (code == ST_SAT) begin
            if (cur == ST_OK) res = ST_SAT;
        end else if (cur == ST_OK || cur == ST_SAT) begin
            res = code;
        end
        return res;
    endfunction

    function automatic t_sat sat_add(t_secs a, t_secs b);
        logic [SECONDS_WIDTH:0] sum;
        t_sat res;
        sum     = {1'b0, a} + {1'b0, b};
        res.ovf = sum[SECONDS_WIDTH];
        res.val = res.ovf ? SEC_MAX : sum[SECONDS_WIDTH-1:0];
        return res;
    endfunction

    function automatic t_sat sat_mul10(t_secs a);
        logic [SECONDS_WIDTH+3:0] p;
        t_sat res;
        p       = (SECONDS_WIDTH+4)'(a) * (SECONDS_WIDTH+4)'(RADIX_DEC);
        res.ovf = p > (SECONDS_WIDTH+4)'(SEC_MAX);
        res.val = res.ovf ? SEC_MAX : p[SECONDS_WIDTH-1:0];
        return res;
    endfunction

    function automatic t_sat sat_mul60(t_secs a);
        logic [SECONDS_WIDTH+5:0] p;
        t_sat res;
        p       = (SECONDS_WIDTH+6)'(a) * (SECONDS_WIDTH+6)'(RADIX_SEX);
        res.ovf = p > (SECONDS_WIDTH+6)'(SEC_MAX);
        res.val = res.ovf ? SEC_MAX : p[SECONDS_WIDTH-1:0];
        return res;
    endfunction

    // Weight of the fraction digit at a given position; zero past unit resolution.
    function automatic t_frac frac_weight(t_widx idx);
        t_frac w;
        case (idx)
            4'd0:    w = FRAC_W'(UNITS_PER_SECOND / 10);
            4'd1:    w = FRAC_W'(UNITS_PER_SECOND / 100);
            4'd2:    w = FRAC_W'(UNITS_PER_SECOND / 1000);
            4'd3:    w = FRAC_W'(UNITS_PER_SECOND / 10000);
            4'd4:    w = FRAC_W'(UNITS_PER_SECOND / 100000);
            4'd5:    w = FRAC_W'(UNITS_PER_SECOND / 1000000);
            4'd6:    w = FRAC_W'(UNITS_PER_SECOND / 10000000);
            4'd7:    w = FRAC_W'(UNITS_PER_SECOND / 100000000);
            4'd8:    w = FRAC_W'(UNITS_PER_SECOND / 1000000000);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/hms_timestamp_parser_core.sv
// Timestamp string parser: one character beat per cycle while o_stall is low, one result per zero byte.
// Throughput: one character per cycle while o_stall is low; the per-character update is a single
// constant multiply-accumulate into the parse state registers.
// An accepted zero byte is captured in the finalize register, then passes through
// the scaling multiply into the output register once the output register is free.
// Reset: synchronous, active low; clears parse state and both valid flags.
`timescale 1ns / 1ps

module hms_timestamp_parser_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_ch,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [62:0]           o_time_units,
    output logic [1:0]            o_status
);
    import hms_pkg::*;

    // parse state
    t_secs   r_secs,    n_secs;
    t_secs   r_field,   n_field;
    t_colons r_colons,  n_colons;
    logic    r_in_frac, n_in_frac;
    t_frac   r_frac,    n_frac;
    t_widx   r_widx,    n_widx;
    t_status r_err,     n_err;

    // finalize stage
    logic    r_p_valid, n_p_valid;
    t_secs   r_p_secs;
    t_frac   r_p_frac;
    t_status r_p_status;

    // output stage
    logic    r_o_valid, n_o_valid;
    t_time   r_o_time;
    t_status r_o_status;

    logic    w_out_free;
    logic    w_p_move;
    logic    w_in_acc;
    logic    w_end;
    logic    w_digit;
    logic [3:0] w_d;
    t_frac   w_weight;
    t_sat    w_fin;
    t_sat    w_m10;
    t_sat    w_a10;
    t_sat    w_close;
    t_sat    w_m60;
    t_status w_fin_status;
    logic [PROD_W-1:0] w_prod;
    logic    w_tsat;

    assign w_out_free = !r_o_valid || !i_stall;
    assign w_p_move   = r_p_valid && w_out_free;
    assign o_stall    = r_p_valid && !w_p_move;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_end      = (i_ch == CH_NUL);
    assign w_digit    = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign w_d        = i_ch[3:0];
    assign w_weight   = frac_weight(r_widx);

    assign w_fin        = sat_add(r_secs, r_field);
    assign w_fin_status = w_fin.ovf ? note_status(r_err, ST_SAT) : r_err;
    assign w_m10        = sat_mul10(r_field);
    assign w_a10        = sat_add(w_m10.val, SECONDS_WIDTH'(w_d));
    assign w_close      = sat_add(r_secs, r_field);
    assign w_m60        = sat_mul60(w_close.val);

    always_comb begin
        n_secs    = r_secs;
        n_field   = r_field;
        n_colons  = r_colons;
        n_in_frac = r_in_frac;
        n_frac    = r_frac;
        n_widx    = r_widx;
        n_err     = r_err;
        if (w_in_acc) begin
            if (w_end) begin
                n_secs    = '0;
                n_field   = '0;
                n_colons  = '0;
                n_in_frac = 1'b0;
                n_frac    = '0;
                n_widx    = '0;
                n_err     = ST_OK;
            end else if (r_err != ST_COLONS && r_err != ST_CHAR) begin
                if (w_digit) begin
                    if (r_in_frac) begin
                        n_frac = r_frac + FRAC_W'(FRAC_W'(w_d) * w_weight);
                        if (w_weight != '0) n_widx = r_widx + t_widx'(1);
                    end else begin
                        n_field = w_a10.val;
                        if (w_m10.ovf || w_a10.ovf) n_err = note_status(r_err, ST_SAT);
                    end
                end else if (i_ch == CH_COLON && !r_in_frac) begin
                    if (r_colons >= COLON_W'(MAX_COLONS)) begin
                        n_err = note_status(r_err, ST_COLONS);
                    end else begin
                        n_colons = r_colons + t_colons'(1);
                        n_secs   = w_m60.val;
                        n_field  = '0;
                        if (w_close.ovf || w_m60.ovf) n_err = note_status(r_err, ST_SAT);
                    end
                end else if (i_ch == CH_DOT && !r_in_frac) begin
                    n_in_frac = 1'b1;
                end else begin
                    n_err = note_status(r_err, ST_CHAR);
                end
            end
        end
    end

    always_comb begin
        n_p_valid = r_p_valid;
        if (w_in_acc && w_end) begin
            n_p_valid = 1'b1;
        end else if (w_p_move) begin
            n_p_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (w_p_move) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    // scale to units and clamp to the 63-bit range
    assign w_prod = PROD_W'(r_p_secs) * PROD_W'(UNITS_PER_SECOND) + PROD_W'(r_p_frac);
    assign w_tsat = w_prod > PROD_W'(TIME_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secs    <= '0;
            r_field   <= '0;
            r_colons  <= '0;
            r_in_frac <= 1'b0;
            r_frac    <= '0;
            r_widx    <= '0;
            r_err     <= ST_OK;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_secs    <= n_secs;
            r_field   <= n_field;
            r_colons  <= n_colons;
            r_in_frac <= n_in_frac;
            r_frac    <= n_frac;
            r_widx    <= n_widx;
            r_err     <= n_err;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_end) begin
            r_p_secs   <= w_fin.val;
            r_p_frac   <= r_frac;
            r_p_status <= w_fin_status;
        end
        if (w_p_move) begin
            r_o_time   <= w_tsat ? TIME_MAX : w_prod[TIME_W-1:0];
            r_o_status <= w_tsat ? note_status(r_p_status, ST_SAT) : r_p_status;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_time_units = r_o_time;
    assign o_status     = r_o_status;

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_end) |=> (r_secs == '0 && r_field == '0 && r_colons == '0
                                 && !r_in_frac && r_err == ST_OK))
        else $error("parse state not cleared after end of string");
    a_colon_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_colons <= COLON_W'(MAX_COLONS))
        else $error("colon count past limit");
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < FRAC_W'(UNITS_PER_SECOND))
        else $error("fraction reached a full second");
    a_pipe_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_move |=> r_o_valid)
        else $error("finalized beat lost before output register");
`endif

endmodule

FILE: dv/tb_hms_timestamp_parser_core.sv
// Self-checking testbench for the timestamp parser core: directed strings, then random traffic.
`timescale 1ns / 1ps

module tb_hms_timestamp_parser_core;
    import hms_pkg::*;

    localparam longint unsigned SEC_LIM  = (64'd1 << SECONDS_WIDTH) - 1;
    localparam longint unsigned TIME_LIM = (64'd1 << TIME_W) - 1;
    localparam longint unsigned UNITS    = UNITS_PER_SECOND;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        t_time   units;
        t_status status;
    } t_stamp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [62:0] o_time_units;
    logic [1:0]  o_status;

    hms_timestamp_parser_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_time_units (o_time_units),
        .o_status     (o_status)
    );

    // Mirror of the parse state
    longint unsigned secs_acc;
    longint unsigned field_acc;
    longint unsigned frac_acc;
    longint unsigned weight_now;
    int              colons_seen;
    bit              after_dot;
    t_status         parse_status;

    t_stamp stamps_due[$];
    int     errors;
    int     cycles;
    int     chars_sent;
    int     strings_sent;
    int     stamps_seen;
    int     status_hits[4];
    int     idle_pct;
    int     stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d stamps still due", cycles, stamps_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    function automatic void clear_parse();
        secs_acc     = 0;
        field_acc    = 0;
        frac_acc     = 0;
        weight_now   = UNITS / RADIX_DEC;
        colons_seen  = 0;
        after_dot    = 1'b0;
        parse_status = ST_OK;
    endfunction

    // Parse errors stick; saturation only marks a clean status.
    function automatic void flag_status(input t_status code);
        if (code == ST_SAT) begin
            if (parse_status == ST_OK) parse_status = ST_SAT;
        end else if (parse_status == ST_OK || parse_status == ST_SAT) begin
            parse_status = code;
        end
    endfunction

    function automatic longint unsigned clamp_sum(input longint unsigned a,
                                                  input longint unsigned b);
        if (a > SEC_LIM - b) begin
            flag_status(ST_SAT);
            return SEC_LIM;
        end
        return a + b;
    endfunction

    function automatic longint unsigned clamp_scale(input longint unsigned a,
                                                    input longint unsigned k);
        if (a > SEC_LIM / k) begin
            flag_status(ST_SAT);
            return SEC_LIM;
        end
        return a * k;
    endfunction

    function automatic void predict_char(input t_ch c);
        longint unsigned secs;
        longint unsigned total;
        longint unsigned digit;
        t_stamp          s;
        digit = c - CH_ZERO;
        if (c == CH_NUL) begin
            secs = clamp_sum(secs_acc, field_acc);
            if (secs > (TIME_LIM - frac_acc) / UNITS) begin
                flag_status(ST_SAT);
                total = TIME_LIM;
            end else begin
                total = secs * UNITS + frac_acc;
            end
            s.units  = t_time'(total);
            s.status = parse_status;
            stamps_due.push_back(s);
            clear_parse();
        end else if (parse_status == ST_COLONS || parse_status == ST_CHAR) begin
            // drop everything up to the terminator
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (after_dot) begin
                frac_acc   = frac_acc + digit * weight_now;
                weight_now = weight_now / RADIX_DEC;
            end else begin
                field_acc = clamp_sum(clamp_scale(field_acc, RADIX_DEC), digit);
            end
        end else if (c == CH_COLON && !after_dot) begin
            if (colons_seen >= MAX_COLONS) begin
                flag_status(ST_COLONS);
            end else begin
                colons_seen++;
                secs_acc  = clamp_scale(clamp_sum(secs_acc, field_acc), RADIX_SEX);
                field_acc = 0;
            end
        end else if (c == CH_DOT && !after_dot) begin
            after_dot = 1'b1;
        end else begin
            flag_status(ST_CHAR);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_stamp want;
        if (i_rst_n && o_valid && !i_stall) begin
            stamps_seen++;
            if (stamps_due.size() == 0) begin
                report_mismatch("result with nothing due, time", o_time_units, 0);
            end else begin
                want = stamps_due.pop_front();
                status_hits[want.status]++;
                if (o_time_units !== want.units)
                    report_mismatch("time_units", o_time_units, want.units);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    // Hold the beat until the block takes it.
    task automatic send_char(input t_ch c);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
        predict_char(c);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(t_ch'(txt[i]));
        send_char(CH_NUL);
        strings_sent++;
    endtask

    // Pause the sender until every due stamp is back.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (stamps_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_stamp();
        t_ch s[$];
        int  kind;
        int  fields;
        int  n;
        int  pos;
        kind = $urandom_range(99);
        if (kind < 8) begin
            n = $urandom_range(0, 8);
            repeat (n) s.push_back(t_ch'($urandom_range(1, 255)));
        end else begin
            fields = $urandom_range(1, (kind < 18) ? 5 : 3);
            for (int f = 0; f < fields; f++) begin
                if (f > 0) s.push_back(CH_COLON);
                n = ($urandom_range(99) < 6) ? $urandom_range(10, 16) : $urandom_range(0, 3);
                repeat (n) s.push_back(CH_ZERO + t_ch'($urandom_range(0, 9)));
            end
            if ($urandom_range(99) < 50) begin
                s.push_back(CH_DOT);
                n = $urandom_range(0, 9);
                repeat (n) s.push_back(CH_ZERO + t_ch'($urandom_range(0, 9)));
            end
            // insert one random nonzero byte into a well-formed stamp
            if (kind >= 18 && kind < 30) begin
                pos = $urandom_range(0, s.size());
                s.insert(pos, t_ch'($urandom_range(1, 255)));
            end
        end
        foreach (s[i]) send_char(s[i]);
        send_char(CH_NUL);
        strings_sent++;
    endtask

    task automatic test_plain_stamps();
        send_text("");
        send_text("59:59:59.9999999");
    endtask

    task automatic test_parse_errors();
        send_text("1:2:3:4");
        send_text(".:");
        send_text("..");
        send_char(8'hFF);
        send_char(CH_NUL);
        strings_sent++;
    endtask

    task automatic test_saturation();
        send_text("9999999999999");
        wait_quiet();
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n_chars);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = chars_sent + n_chars;
        while (chars_sent < target) send_random_stamp();
        wait_quiet();
    endtask

    initial begin
        errors       = 0;
        cycles       = 0;
        chars_sent   = 0;
        strings_sent = 0;
        stamps_seen  = 0;
        status_hits  = '{default: 0};
        idle_pct     = 0;
        stall_pct    = 0;
        clear_parse();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ch    <= CH_NUL;
        i_stall <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_stamps();
        test_parse_errors();
        test_saturation();
        test_random_traffic(0, 0, 500);
        test_random_traffic(51, 0, 500);
        test_random_traffic(0, 51, 500);
        test_random_traffic(26, 26, 500);

        $display("Parsed %0d stamps of %0d strings from %0d character beats, four idle/stall mixes",
                 stamps_seen, strings_sent, chars_sent);
        $display("Status mix ok/colons/char/saturated: %0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hms_pkg.sv
rtl/hms_timestamp_parser_core.sv
dv/tb_hms_timestamp_parser_core.sv
